/* sv/rli_pkg.sv */
// Shared constants and types for the RGB LUT interpolator.
package rli_pkg;

	localparam int TABLE_DEPTH   = 256;
	localparam int FRACTION_BITS = 16;
	localparam int SAMPLE_W      = 24;
	localparam int CHANNELS      = 3;
	localparam int ADDR_W        = $clog2(TABLE_DEPTH);
	localparam int CNT_W         = 9;
	localparam int INDEX_W       = 8;
	localparam int WEIGHT_W      = SAMPLE_W + 1;
	localparam int POS_W         = SAMPLE_W + ADDR_W + 1;
	localparam int PROD_W        = 2 * WEIGHT_W;
	localparam int SUM_W         = PROD_W - FRACTION_BITS + 1;
	localparam int PADDR_W       = 5;
	localparam int PDATA_W       = 32;

	localparam logic [2:0] REG_ENTRY_COUNT = 3'd0;
	localparam logic [2:0] REG_LOWER_RED   = 3'd1;
	localparam logic [2:0] REG_LOWER_GREEN = 3'd2;
	localparam logic [2:0] REG_LOWER_BLUE  = 3'd3;
	localparam logic [2:0] REG_UPPER_RED   = 3'd4;
	localparam logic [2:0] REG_UPPER_GREEN = 3'd5;
	localparam logic [2:0] REG_UPPER_BLUE  = 3'd6;

	typedef enum logic [1:0] {
		REGION_INNER,
		REGION_LOWER,
		REGION_UPPER
	} region_t;

	typedef struct packed {
		region_t                     region;
		logic signed [WEIGHT_W-1:0]  weight;
	} chan_s1_t;

endpackage

/* sv/rgb_lut_interpolate.sv */
// RGB per-channel 1D LUT with linear interpolation and extrapolation, top level.
//
// Input channel (in_valid/in_ready) carries one word per cycle while in_ready
// is high. op 1 writes entry entry_index of the red, green and blue tables; it
// yields no result. op 0 is a signed Q8.16 pixel; each channel is scaled by
// entry_count-1 (clamped to 1..255) and interpolated between neighbouring
// entries, or extrapolated with the lower or upper slope outside [0,1). Results
// saturate to Q8.16; clipped flags it. Output channel (out_valid/out_ready)
// gives one word per pixel. Throughput is one word per cycle unless the output
// stalls: stage 0 multiplies the sample by the interval count to form the
// table addresses, the table (one bank per channel, two read ports) is read at
// the accepting edge, stage 1 does the 25x25 product, stage 2 rounds, adds and
// saturates into the output register. Each stage holds only when the stage
// after it is full and stalled, so input is still taken while a result waits,
// as long as a stage is empty. Reset clears the valid bits and sets entry_count
// to 2 and every slope to 1.0; table contents are undefined until written.
// The user must see that registers are written over the APB port only while
// the block is idle; the block does not enforce it.
module rgb_lut_interpolate
	import rli_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       op,
	input  logic [INDEX_W-1:0]         entry_index,
	input  logic signed [SAMPLE_W-1:0] red_in,
	input  logic signed [SAMPLE_W-1:0] green_in,
	input  logic signed [SAMPLE_W-1:0] blue_in,

	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] red_out,
	output logic signed [SAMPLE_W-1:0] green_out,
	output logic signed [SAMPLE_W-1:0] blue_out,
	output logic                       clipped,

	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [PADDR_W-1:0]         paddr,
	input  logic [PDATA_W-1:0]         pwdata,
	output logic [PDATA_W-1:0]         prdata,
	output logic                       pready
);

	localparam logic signed [WEIGHT_W-1:0] ONE = WEIGHT_W'(2 ** FRACTION_BITS);
	localparam logic signed [PROD_W-1:0]   HALF = PROD_W'(2 ** (FRACTION_BITS - 1));
	localparam logic signed [SAMPLE_W-1:0] OUT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] OUT_MIN = ~OUT_MAX;
	localparam logic signed [SUM_W-1:0]    SAT_HI = SUM_W'(OUT_MAX);
	localparam logic signed [SUM_W-1:0]    SAT_LO = SUM_W'(OUT_MIN);

	// configuration
	logic [CNT_W-1:0]           entry_count_q;
	logic signed [SAMPLE_W-1:0] slope_lo_q [CHANNELS];
	logic signed [SAMPLE_W-1:0] slope_hi_q [CHANNELS];
	logic [2:0]                 reg_idx;
	logic                       cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= CNT_W'(2);
			for (int c = 0; c < CHANNELS; c++) begin
				slope_lo_q[c] <= SAMPLE_W'(2 ** FRACTION_BITS);
				slope_hi_q[c] <= SAMPLE_W'(2 ** FRACTION_BITS);
			end
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_ENTRY_COUNT: entry_count_q <= pwdata[CNT_W-1:0];
				REG_LOWER_RED:   slope_lo_q[0] <= pwdata[SAMPLE_W-1:0];
				REG_LOWER_GREEN: slope_lo_q[1] <= pwdata[SAMPLE_W-1:0];
				REG_LOWER_BLUE:  slope_lo_q[2] <= pwdata[SAMPLE_W-1:0];
				REG_UPPER_RED:   slope_hi_q[0] <= pwdata[SAMPLE_W-1:0];
				REG_UPPER_GREEN: slope_hi_q[1] <= pwdata[SAMPLE_W-1:0];
				REG_UPPER_BLUE:  slope_hi_q[2] <= pwdata[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ENTRY_COUNT: prdata = PDATA_W'(entry_count_q);
			REG_LOWER_RED:   prdata = PDATA_W'(slope_lo_q[0]);
			REG_LOWER_GREEN: prdata = PDATA_W'(slope_lo_q[1]);
			REG_LOWER_BLUE:  prdata = PDATA_W'(slope_lo_q[2]);
			REG_UPPER_RED:   prdata = PDATA_W'(slope_hi_q[0]);
			REG_UPPER_GREEN: prdata = PDATA_W'(slope_hi_q[1]);
			REG_UPPER_BLUE:  prdata = PDATA_W'(slope_hi_q[2]);
			default:         prdata = '0;
		endcase
	end

	// interval count, clamped to the table
	logic [ADDR_W-1:0] n_w;

	always_comb begin
		if (entry_count_q < CNT_W'(2))
			n_w = ADDR_W'(1);
		else if (32'(entry_count_q) > TABLE_DEPTH)
			n_w = ADDR_W'(TABLE_DEPTH - 1);
		else
			n_w = ADDR_W'(entry_count_q - CNT_W'(1));
	end

	// flow control
	logic valid_s1, valid_s2, out_valid_q;
	logic en1, en2, en_out;
	logic accept, wr_en;

	assign en_out   = !out_valid_q || out_ready;
	assign en2      = en_out || !valid_s2;
	assign en1      = en2 || !valid_s1;
	assign in_ready = en1;
	assign accept   = in_valid && in_ready;
	assign wr_en    = accept && op && (32'(entry_index) < TABLE_DEPTH);

	// stage 0: position and table addresses
	logic signed [SAMPLE_W-1:0] sample [CHANNELS];
	logic [ADDR_W-1:0]          addr_a [CHANNELS];
	logic [ADDR_W-1:0]          addr_b [CHANNELS];
	chan_s1_t                   chan_d [CHANNELS];

	assign sample[0] = red_in;
	assign sample[1] = green_in;
	assign sample[2] = blue_in;

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			logic signed [POS_W-1:0]    pos;
			logic signed [WEIGHT_W-1:0] vx;
			logic [ADDR_W-1:0]          idx;
			pos = $signed({{(POS_W-SAMPLE_W){sample[c][SAMPLE_W-1]}}, sample[c]}) *
				$signed({{(POS_W-ADDR_W){1'b0}}, n_w});
			vx  = WEIGHT_W'(sample[c]);
			idx = pos[FRACTION_BITS +: ADDR_W];
			addr_b[c] = idx + ADDR_W'(1);
			if (sample[c][SAMPLE_W-1]) begin
				addr_a[c] = '0;
				chan_d[c].region = REGION_LOWER;
				chan_d[c].weight = vx;
			end else if (vx >= ONE) begin
				addr_a[c] = n_w;
				chan_d[c].region = REGION_UPPER;
				chan_d[c].weight = vx - ONE;
			end else begin
				addr_a[c] = idx;
				chan_d[c].region = REGION_INNER;
				chan_d[c].weight = WEIGHT_W'(pos[FRACTION_BITS-1:0]);
			end
		end
	end

	// table memory, one bank per channel, one write and two read ports
	logic signed [SAMPLE_W-1:0] tbl_mem [CHANNELS][TABLE_DEPTH];
	logic signed [SAMPLE_W-1:0] rd_a_s1 [CHANNELS];
	logic signed [SAMPLE_W-1:0] rd_b_s1 [CHANNELS];
	chan_s1_t                   chan_s1 [CHANNELS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int c = 0; c < CHANNELS; c++)
				tbl_mem[c][ADDR_W'(entry_index)] <= sample[c];
		end
		if (en1) begin
			for (int c = 0; c < CHANNELS; c++) begin
				rd_a_s1[c] <= tbl_mem[c][addr_a[c]];
				rd_b_s1[c] <= tbl_mem[c][addr_b[c]];
				chan_s1[c] <= chan_d[c];
			end
		end
	end

	// stage 1: product
	logic signed [PROD_W-1:0]   prod_d  [CHANNELS];
	logic signed [PROD_W-1:0]   prod_s2 [CHANNELS];
	logic signed [SAMPLE_W-1:0] base_s2 [CHANNELS];

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			logic signed [WEIGHT_W-1:0] opa;
			case (chan_s1[c].region)
				REGION_INNER: opa = WEIGHT_W'(rd_b_s1[c]) - WEIGHT_W'(rd_a_s1[c]);
				REGION_LOWER: opa = WEIGHT_W'(slope_lo_q[c]);
				REGION_UPPER: opa = WEIGHT_W'(slope_hi_q[c]);
				default:      opa = '0;
			endcase
			prod_d[c] = PROD_W'(opa) * PROD_W'($signed(chan_s1[c].weight));
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int c = 0; c < CHANNELS; c++) begin
				prod_s2[c] <= prod_d[c];
				base_s2[c] <= rd_a_s1[c];
			end
		end
	end

	// stage 2: round, add, saturate
	logic signed [SAMPLE_W-1:0] res_d [CHANNELS];
	logic                       clip_d;
	logic signed [SAMPLE_W-1:0] out_q [CHANNELS];
	logic                       clipped_q;

	always_comb begin
		clip_d = 1'b0;
		for (int c = 0; c < CHANNELS; c++) begin
			logic signed [PROD_W-1:0] rsum;
			logic signed [SUM_W-1:0]  sum;
			rsum = prod_s2[c] + HALF;
			sum  = SUM_W'(base_s2[c]) + SUM_W'(rsum >>> FRACTION_BITS);
			if (sum > SAT_HI) begin
				res_d[c] = OUT_MAX;
				clip_d   = 1'b1;
			end else if (sum < SAT_LO) begin
				res_d[c] = OUT_MIN;
				clip_d   = 1'b1;
			end else begin
				res_d[c] = sum[SAMPLE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && valid_s2) begin
			for (int c = 0; c < CHANNELS; c++)
				out_q[c] <= res_d[c];
			clipped_q <= clip_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1)
				valid_s1 <= accept && !op;
			if (en2)
				valid_s2 <= valid_s1;
			if (en_out)
				out_valid_q <= valid_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign red_out   = out_q[0];
	assign green_out = out_q[1];
	assign blue_out  = out_q[2];
	assign clipped   = clipped_q;

	// checks
	a_pixel_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !op |=> valid_s1)
		else $error("accepted pixel missing from stage 1");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && valid_s1 && valid_s2 |-> !in_ready)
		else $error("input taken with pipeline full and stalled");

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !en2 |=> valid_s2 && $stable(prod_s2[0]) && $stable(base_s2[0]))
		else $error("stage 2 changed while stalled");

	a_clip_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> (red_out == OUT_MAX || red_out == OUT_MIN ||
			green_out == OUT_MAX || green_out == OUT_MIN ||
			blue_out == OUT_MAX || blue_out == OUT_MIN))
		else $error("clip flag without a saturated channel");

endmodule

/* tb/rgb_lut_interpolate_checker.sv */
// Op codes for the testbench and a checker that predicts and compares every remapped pixel word.
package rli_tb_pkg;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_WRITE = 1'b1
	} op_code_t;

endpackage

module rgb_lut_interpolate_checker
	import rli_pkg::*;
	import rli_tb_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic                       op,
	input  logic [INDEX_W-1:0]         entry_index,
	input  logic signed [SAMPLE_W-1:0] red_in,
	input  logic signed [SAMPLE_W-1:0] green_in,
	input  logic signed [SAMPLE_W-1:0] blue_in,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic signed [SAMPLE_W-1:0] red_out,
	input  logic signed [SAMPLE_W-1:0] green_out,
	input  logic signed [SAMPLE_W-1:0] blue_out,
	input  logic                       clipped,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [PADDR_W-1:0]         paddr,
	input  logic [PDATA_W-1:0]         pwdata,
	output int                         mismatches,
	output int                         words_pending,
	output int                         pixels_checked,
	output int                         clip_count,
	output int                         lower_hits,
	output int                         inner_hits,
	output int                         upper_hits
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint SAT_HI = (longint'(1) << (SAMPLE_W - 1)) - 1;
	localparam longint SAT_LO = -(longint'(1) << (SAMPLE_W - 1));

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] red;
		logic signed [SAMPLE_W-1:0] green;
		logic signed [SAMPLE_W-1:0] blue;
		logic                       clip;
	} pixel_word_t;

	logic signed [SAMPLE_W-1:0] lut_tab [CHANNELS][TABLE_DEPTH];
	logic signed [SAMPLE_W-1:0] lower_slope [CHANNELS];
	logic signed [SAMPLE_W-1:0] upper_slope [CHANNELS];
	logic [CNT_W-1:0]           entry_count;
	pixel_word_t                expected_pixels [$];

	// floor((x + half lsb) / 2^F)
	function automatic longint round_q(input longint x);
		return (x + (longint'(1) << (FRACTION_BITS - 1))) >>> FRACTION_BITS;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] lut_remap(input int ch,
			input logic signed [SAMPLE_W-1:0] v, input longint span, inout logic clip);
		longint one, pos, r, a, b;
		one = longint'(1) << FRACTION_BITS;
		pos = longint'(v) * span;
		if (pos < 0) begin
			lower_hits++;
			r = longint'(lut_tab[ch][0]) + round_q(longint'(lower_slope[ch]) * longint'(v));
		end else if (pos >= span * one) begin
			upper_hits++;
			r = longint'(lut_tab[ch][span]) +
				round_q(longint'(upper_slope[ch]) * (longint'(v) - one));
		end else begin
			inner_hits++;
			a = longint'(lut_tab[ch][pos >>> FRACTION_BITS]);
			b = longint'(lut_tab[ch][(pos >>> FRACTION_BITS) + 1]);
			r = a + round_q((b - a) * (pos & (one - 1)));
		end
		if (r > SAT_HI) begin
			clip = 1'b1;
			r = SAT_HI;
		end
		if (r < SAT_LO) begin
			clip = 1'b1;
			r = SAT_LO;
		end
		return r[SAMPLE_W-1:0];
	endfunction

	task automatic check_field(input string name, input logic signed [SAMPLE_W-1:0] want,
			input logic signed [SAMPLE_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		pixel_word_t want;
		logic        clip;
		longint      span;
		if (!arst_n) begin
			entry_count = 9'd2;
			for (int c = 0; c < CHANNELS; c++) begin
				lower_slope[c] = 24'sd65536;
				upper_slope[c] = 24'sd65536;
			end
			expected_pixels.delete();
			mismatches = 0;
			pixels_checked = 0;
			clip_count = 0;
			lower_hits = 0;
			inner_hits = 0;
			upper_hits = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					mismatches++;
					$error("output word with no pixel outstanding");
				end else begin
					want = expected_pixels.pop_front();
					check_field("red_out", want.red, red_out);
					check_field("green_out", want.green, green_out);
					check_field("blue_out", want.blue, blue_out);
					check_field("clipped", want.clip, clipped);
					pixels_checked++;
					if (want.clip)
						clip_count++;
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_ENTRY_COUNT: entry_count = pwdata[CNT_W-1:0];
					REG_LOWER_RED:   lower_slope[0] = pwdata[SAMPLE_W-1:0];
					REG_LOWER_GREEN: lower_slope[1] = pwdata[SAMPLE_W-1:0];
					REG_LOWER_BLUE:  lower_slope[2] = pwdata[SAMPLE_W-1:0];
					REG_UPPER_RED:   upper_slope[0] = pwdata[SAMPLE_W-1:0];
					REG_UPPER_GREEN: upper_slope[1] = pwdata[SAMPLE_W-1:0];
					REG_UPPER_BLUE:  upper_slope[2] = pwdata[SAMPLE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (op == OP_WRITE) begin
					lut_tab[0][entry_index] = red_in;
					lut_tab[1][entry_index] = green_in;
					lut_tab[2][entry_index] = blue_in;
				end else begin
					if (entry_count < 2)
						span = 1;
					else if (entry_count > TABLE_DEPTH)
						span = TABLE_DEPTH - 1;
					else
						span = entry_count - 1;
					clip = 1'b0;
					want.red = lut_remap(0, red_in, span, clip);
					want.green = lut_remap(1, green_in, span, clip);
					want.blue = lut_remap(2, blue_in, span, clip);
					want.clip = clip;
					expected_pixels.push_back(want);
				end
			end
		end
		words_pending = expected_pixels.size();
	end

endmodule

/* tb/rgb_lut_interpolate_tb.sv */
// Stimulus and verdict for the RGB LUT interpolator, with the checker alongside the block.
module rgb_lut_interpolate_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rli_pkg::*;
	import rli_tb_pkg::*;

	localparam int SAMPLE_MAX   = (1 << (SAMPLE_W - 1)) - 1;
	localparam int SAMPLE_MIN   = -(1 << (SAMPLE_W - 1));
	localparam int ONE_Q        = 1 << FRACTION_BITS;
	localparam int LONG_HOLD    = 300;
	localparam int PHASE_WORDS  = 215;
	localparam int RUN_LIMIT_NS = 5_000_000;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic                       op;
	logic [INDEX_W-1:0]         entry_index;
	logic signed [SAMPLE_W-1:0] red_in;
	logic signed [SAMPLE_W-1:0] green_in;
	logic signed [SAMPLE_W-1:0] blue_in;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [SAMPLE_W-1:0] red_out;
	logic signed [SAMPLE_W-1:0] green_out;
	logic signed [SAMPLE_W-1:0] blue_out;
	logic                       clipped;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [PADDR_W-1:0]         paddr;
	logic [PDATA_W-1:0]         pwdata;
	logic [PDATA_W-1:0]         prdata;
	logic                       pready;

	int mismatches, words_pending, pixels_checked, clip_count;
	int lower_hits, inner_hits, upper_hits;
	int words_sent, writes_sent;
	bit tx_burst, rx_burst, hold_req;
	bit entry_written [TABLE_DEPTH];

	rgb_lut_interpolate dut (.*);

	rgb_lut_interpolate_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("FAIL");
		$finish;
	end

	task automatic send_word(input op_code_t kind, input logic [INDEX_W-1:0] idx,
			input logic signed [SAMPLE_W-1:0] r, g, b);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 11);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		op = kind;
		entry_index = idx;
		red_in = r;
		green_in = g;
		blue_in = b;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		words_sent++;
		if (kind == OP_WRITE) begin
			writes_sent++;
			entry_written[idx] = 1'b1;
		end
		if (words_sent % 97 == 0)
			tx_burst = ($urandom_range(0, 3) == 0);
	endtask

	task automatic end_phase();
		@(negedge clk);
		in_valid = 1'b0;
		wait (words_pending == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [PDATA_W-1:0] val);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic apply_settings(input int count, input logic signed [SAMPLE_W-1:0] lr, lg, lb,
			input logic signed [SAMPLE_W-1:0] ur, ug, ub);
		cfg_write(REG_ENTRY_COUNT, count);
		cfg_write(REG_LOWER_RED, lr);
		cfg_write(REG_LOWER_GREEN, lg);
		cfg_write(REG_LOWER_BLUE, lb);
		cfg_write(REG_UPPER_RED, ur);
		cfg_write(REG_UPPER_GREEN, ug);
		cfg_write(REG_UPPER_BLUE, ub);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 50)
			return $urandom_range(0, ONE_Q - 1);
		if (sel < 62)
			return -int'($urandom_range(1, 2 * ONE_Q));
		if (sel < 74)
			return ONE_Q + int'($urandom_range(0, 2 * ONE_Q));
		if (sel < 90)
			return $urandom;
		case ($urandom_range(0, 5))
			0: return 0;
			1: return ONE_Q - 1;
			2: return ONE_Q;
			3: return -1;
			4: return SAMPLE_MIN;
			default: return SAMPLE_MAX;
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_entry();
		if ($urandom_range(0, 99) < 60)
			return $urandom;
		return int'($urandom_range(0, 4 * ONE_Q)) - 2 * ONE_Q;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_slope();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 40)
			return $urandom;
		if (sel < 80)
			return int'($urandom_range(0, 8 * ONE_Q)) - 4 * ONE_Q;
		case ($urandom_range(0, 4))
			0: return SAMPLE_MIN;
			1: return SAMPLE_MAX;
			2: return 0;
			3: return -ONE_Q;
			default: return ONE_Q;
		endcase
	endfunction

	// entries 0..count-1 are loaded before any pixel of this phase
	task automatic run_phase(input int count, input bit squeeze);
		int i;
		for (i = 0; i < count; i++) begin
			if (!entry_written[i])
				send_word(OP_WRITE, i, pick_entry(), pick_entry(), pick_entry());
		end
		for (i = 0; i < PHASE_WORDS; i++) begin
			if (squeeze && i == PHASE_WORDS / 3)
				hold_req = 1'b1;
			if ($urandom_range(0, 99) < 15)
				send_word(OP_WRITE, $urandom_range(0, TABLE_DEPTH - 1),
					pick_entry(), pick_entry(), pick_entry());
			else
				send_word(OP_PIXEL, $urandom_range(0, TABLE_DEPTH - 1),
					pick_sample(), pick_sample(), pick_sample());
		end
		end_phase();
	endtask

	initial begin : receiver
		int gap, taken;
		out_ready = 1'b0;
		taken = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else begin
				gap = rx_burst ? 0 : $urandom_range(0, 11);
				if (gap > 0) begin
					out_ready = 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
			if (taken % 83 == 0)
				rx_burst = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_PIXEL;
		entry_index = '0;
		red_in = '0;
		green_in = '0;
		blue_in = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		words_sent = 0;
		writes_sent = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: two entries, unit slopes
		send_word(OP_WRITE, 0, SAMPLE_MIN, 1, ONE_Q);
		send_word(OP_WRITE, 1, SAMPLE_MAX, 0, -ONE_Q);
		send_word(OP_PIXEL, 0, 0, ONE_Q / 2, ONE_Q - 1);
		send_word(OP_PIXEL, 0, ONE_Q / 2, ONE_Q / 2, ONE_Q / 2);
		send_word(OP_PIXEL, 0, ONE_Q - 1, 0, ONE_Q);
		send_word(OP_PIXEL, 0, ONE_Q, ONE_Q - 1, -1);
		send_word(OP_PIXEL, 0, -1, -1, 0);
		send_word(OP_PIXEL, 0, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
		send_word(OP_PIXEL, 0, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
		send_word(OP_WRITE, TABLE_DEPTH - 1, SAMPLE_MAX, SAMPLE_MIN, 0);
		send_word(OP_PIXEL, TABLE_DEPTH - 1, ONE_Q / 4, 3 * ONE_Q / 4, 1);
		end_phase();

		apply_settings(TABLE_DEPTH, SAMPLE_MAX, SAMPLE_MIN, 0, SAMPLE_MIN, SAMPLE_MAX, ONE_Q);
		run_phase(TABLE_DEPTH, 1'b1);
		apply_settings(2, pick_slope(), pick_slope(), pick_slope(),
			pick_slope(), pick_slope(), pick_slope());
		run_phase(2, 1'b0);
		apply_settings(3, SAMPLE_MIN, SAMPLE_MAX, -ONE_Q, SAMPLE_MAX, 0, SAMPLE_MIN);
		run_phase(3, 1'b0);
		apply_settings(17, pick_slope(), pick_slope(), pick_slope(),
			pick_slope(), pick_slope(), pick_slope());
		run_phase(17, 1'b1);
		apply_settings(TABLE_DEPTH - 1, pick_slope(), pick_slope(), pick_slope(),
			pick_slope(), pick_slope(), pick_slope());
		run_phase(TABLE_DEPTH - 1, 1'b0);
		apply_settings($urandom_range(2, TABLE_DEPTH), pick_slope(), pick_slope(), pick_slope(),
			pick_slope(), pick_slope(), pick_slope());
		run_phase(TABLE_DEPTH, 1'b0);

		wait (words_pending == 0);
		repeat (10) @(posedge clk);
		$display("Checked %0d pixel words and %0d table writes across six register settings.",
			pixels_checked, writes_sent);
		$display("Channel samples: %0d below zero, %0d inside, %0d at or above one; %0d clipped.",
			lower_hits, inner_hits, upper_hits, clip_count);
		if (mismatches == 0 && words_pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* rgb_lut_interpolate.f */
sv/rli_pkg.sv
sv/rgb_lut_interpolate.sv
tb/rgb_lut_interpolate_checker.sv
tb/rgb_lut_interpolate_tb.sv
